// ===== design/rsd_pkg.sv =====
// Package for the radial spotlight dimmer.
// Holds payload and pipeline structs, fixed widths and shared constants.
// No dependencies.
package rsd_pkg;

  // Field widths fixed by the pixel format
  localparam int unsigned COORD_W = 12;
  localparam int unsigned LUM_W   = 16;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned DIFF_W  = 15;  // signed pixel minus center
  localparam int unsigned SQ_W    = 28;  // one squared difference
  localparam int unsigned SUM_W   = 29;  // squared distance
  localparam int unsigned NEAR_W  = 15;  // squared distance inside the radius

  // Square root: 32-bit radicand, 16-bit root, remainder below 2^17
  localparam int unsigned RAD_W        = 16;
  localparam int unsigned ROOT_W       = 16;
  localparam int unsigned REM_W        = 17;
  localparam int unsigned SQRT_STAGES  = 4;
  localparam int unsigned SQRT_STEPS   = 4;

  // Radius 160, squared
  localparam int unsigned RADIUS_SQ = 25600;

  // 51200 = 2^11 * 25; divide by 25 through a reciprocal
  localparam int unsigned SCALE_SHIFT = 11;
  localparam int unsigned QUO_IN_W    = 20;
  localparam int unsigned RECIP_W     = 22;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned RECIP_25    = 2684355;  // ceil(2^26 / 25)
  localparam int unsigned QUO_W       = 15;

  // Defaults for top-level parameters
  localparam int unsigned MAX_DIM_DEF       = 4096;
  localparam int unsigned LUM_FRAC_BITS_DEF = 15;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;
  localparam cfg_idx_t CFG_CENTER_X = 1'd0;
  localparam cfg_idx_t CFG_CENTER_Y = 1'd1;

  // Input and result transactions
  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [LUM_W-1:0]   lum_in;
  } pix_t;

  typedef struct packed {
    logic [LUM_W-1:0] lum_out;
  } res_t;

  // Between distance front end and square root
  typedef struct packed {
    logic             far;
    logic [RAD_W-1:0] rad;
    logic [LUM_W-1:0] lum;
  } dist_t;

  // Between square root stages
  typedef struct packed {
    logic              far;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [LUM_W-1:0]  lum;
  } root_t;

endpackage

// ===== design/rsd_stream_if.sv =====
// Valid/ready stream interface for the radial spotlight dimmer.
// Payload type is a parameter; no other dependencies.
interface rsd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rsd_distance.sv =====
// Distance front end: saturate, subtract center, square, sum, radius check.
// Three register stages; holds the center registers. Uses rsd_pkg.
module rsd_distance #(
  parameter int unsigned MAX_DIM = rsd_pkg::MAX_DIM_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  rsd_pkg::cfg_idx_t  cfg_idx_i,
  input  rsd_pkg::cfg_data_t cfg_data_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  rsd_pkg::pix_t      data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output rsd_pkg::dist_t     data_o
);
  import rsd_pkg::*;

  localparam int unsigned CMP_W = COORD_W + 1;

  logic [CFG_W-1:0] center_x_q, center_y_q;

  logic                     v1_q, v2_q, v3_q;
  logic                     en1, en2, en3;
  logic signed [DIFF_W-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [LUM_W-1:0]         lum1_q, lum2_q;
  logic [COORD_W-1:0]       x_sat, y_sat;
  logic signed [2*DIFF_W-1:0] px, py;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  logic [SUM_W-1:0]         sum;
  dist_t                    dist_d, dist_q;

  // Center registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X: center_x_q <= cfg_data_i;
        CFG_CENTER_Y: center_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stall chain: a stage moves when empty or when its successor moves
  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v3_q;
  assign data_o  = dist_q;

  // Stage 1: clamp coordinates to the image, subtract center
  always_comb begin
    x_sat = ({1'b0, data_i.pixel_x} >= CMP_W'(MAX_DIM)) ? COORD_W'(MAX_DIM - 1)
                                                        : data_i.pixel_x;
    y_sat = ({1'b0, data_i.pixel_y} >= CMP_W'(MAX_DIM)) ? COORD_W'(MAX_DIM - 1)
                                                        : data_i.pixel_y;
    dx_d  = $signed({3'b000, x_sat}) - $signed({center_x_q[CFG_W-1], center_x_q});
    dy_d  = $signed({3'b000, y_sat}) - $signed({center_y_q[CFG_W-1], center_y_q});
  end

  // Stage 2: squares
  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;

  // Stage 3: sum and radius compare
  always_comb begin
    sum         = {1'b0, sqx_q} + {1'b0, sqy_q};
    dist_d.far  = sum > SUM_W'(RADIUS_SQ);
    dist_d.rad  = {1'b0, sum[NEAR_W-1:0]};
    dist_d.lum  = lum2_q;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en1) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      lum1_q <= data_i.lum_in;
    end
    if (en2) begin
      sqx_q  <= SQ_W'(px);
      sqy_q  <= SQ_W'(py);
      lum2_q <= lum1_q;
    end
    if (en3) begin
      dist_q <= dist_d;
    end
  end

endmodule

// ===== design/rsd_sqrt_stage.sv =====
// One stage of the digit-by-digit square root: SQRT_STEPS root bits per stage.
// Carries the remaining radicand, partial root and remainder. Uses rsd_pkg.
module rsd_sqrt_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rsd_pkg::root_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rsd_pkg::root_t data_o
);
  import rsd_pkg::*;

  localparam int unsigned ACC_W = REM_W + 2;

  logic              v_q;
  logic              en;
  root_t             st_d, st_q;
  logic [ACC_W-1:0]  acc, trial;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [RAD_W-1:0]  rad;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign data_o  = st_q;

  // Restoring square root, two radicand bits per step
  always_comb begin
    rem  = data_i.rem;
    root = data_i.root;
    rad  = data_i.rad;
    acc  = '0;
    trial = '0;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      acc   = {rem, rad[RAD_W-1 -: 2]};
      trial = ACC_W'({root, 2'b01});
      if (acc >= trial) begin
        rem  = REM_W'(acc - trial);
        root = {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  = REM_W'(acc);
        root = {root[ROOT_W-2:0], 1'b0};
      end
      rad = {rad[RAD_W-3:0], 2'b00};
    end
    st_d      = data_i;
    st_d.rem  = rem;
    st_d.root = root;
    st_d.rad  = rad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) st_q <= st_d;
  end

endmodule

// ===== design/rsd_gain.sv =====
// Gain and output: distance to falloff via reciprocal divide, then luminance
// scaling. Two register stages, the second is the output register. Uses rsd_pkg.
module rsd_gain #(
  parameter int unsigned LUM_FRAC_BITS = rsd_pkg::LUM_FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rsd_pkg::root_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rsd_pkg::res_t  data_o
);
  import rsd_pkg::*;

  localparam int unsigned SCALED_W = ROOT_W + LUM_FRAC_BITS;
  localparam int unsigned PROD_W   = QUO_IN_W + RECIP_W;
  localparam int unsigned LPROD_W  = 2 * LUM_W;
  localparam logic [LUM_W-1:0] GAIN_ONE = LUM_W'(1 << LUM_FRAC_BITS);
  localparam logic [LUM_W-1:0] GAIN_FAR = LUM_W'((2 * (1 << LUM_FRAC_BITS) + 5) / 10);

  logic                v1_q, v2_q;
  logic                en1, en2;
  logic [SCALED_W-1:0] scaled;
  logic [QUO_IN_W-1:0] quo_in;
  logic [PROD_W-1:0]   qprod;
  logic [QUO_W-1:0]    quo_q;
  logic                far_q;
  logic [LUM_W-1:0]    lum_q;
  logic [LUM_W-1:0]    gain;
  logic [LPROD_W-1:0]  lprod;
  res_t                res_d, res_q;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v2_q;
  assign data_o  = res_q;

  // Stage 1: floor(d * ONE / 51200) = floor(floor(d * ONE / 2^11) / 25)
  always_comb begin
    scaled = SCALED_W'(data_i.root) << LUM_FRAC_BITS;
    quo_in = QUO_IN_W'(scaled >> SCALE_SHIFT);
    qprod  = PROD_W'(quo_in) * PROD_W'(RECIP_25);
  end

  // Stage 2: pick gain, scale luminance
  always_comb begin
    gain          = far_q ? GAIN_FAR : (GAIN_ONE - LUM_W'(quo_q));
    lprod         = LPROD_W'(lum_q) * LPROD_W'(gain);
    res_d.lum_out = LUM_W'(lprod >> LUM_FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      quo_q <= QUO_W'(qprod >> RECIP_SHIFT);
      far_q <= data_i.far;
      lum_q <= data_i.lum;
    end
    if (en2) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== design/radial_spotlight_dimmer.sv =====
// Radial spotlight dimmer: luminance falls off with distance from a center.
// Throughput 1 pixel/cycle unless a low out_if.ready stalls the pipeline.
// Depth is set by the 16-bit root (4 stages of 4 steps) plus 3 distance and
// 2 gain stages. Async active-low reset empties the pipeline and zeroes the
// center registers; no clearing pass.
// Uses rsd_pkg, rsd_stream_if, rsd_distance, rsd_sqrt_stage, rsd_gain.
module radial_spotlight_dimmer #(
  parameter int unsigned MAX_DIM       = rsd_pkg::MAX_DIM_DEF,
  parameter int unsigned LUM_FRAC_BITS = rsd_pkg::LUM_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  rsd_pkg::cfg_idx_t  cfg_idx_i,
  input  rsd_pkg::cfg_data_t cfg_data_i,
  rsd_stream_if.sink         in_if,
  rsd_stream_if.source       out_if
);
  import rsd_pkg::*;

  dist_t dist_data;
  logic  dist_valid, dist_ready;
  root_t sq_data  [SQRT_STAGES+1];
  logic  sq_valid [SQRT_STAGES+1];
  logic  sq_ready [SQRT_STAGES+1];
  res_t  res;

  // Distance front end
  rsd_distance #(
    .MAX_DIM(MAX_DIM)
  ) u_distance (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .valid_i   (in_if.valid),
    .ready_o   (in_if.ready),
    .data_i    (in_if.data),
    .valid_o   (dist_valid),
    .ready_i   (dist_ready),
    .data_o    (dist_data)
  );

  // Radicand is d2 * 2^16; root and remainder start at zero
  always_comb begin
    sq_data[0].far  = dist_data.far;
    sq_data[0].rad  = dist_data.rad;
    sq_data[0].rem  = '0;
    sq_data[0].root = '0;
    sq_data[0].lum  = dist_data.lum;
  end
  assign sq_valid[0] = dist_valid;
  assign dist_ready  = sq_ready[0];

  // Square root pipeline
  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
    rsd_sqrt_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sq_valid[s]),
      .ready_o(sq_ready[s]),
      .data_i (sq_data[s]),
      .valid_o(sq_valid[s+1]),
      .ready_i(sq_ready[s+1]),
      .data_o (sq_data[s+1])
    );
  end

  // Gain and output register
  rsd_gain #(
    .LUM_FRAC_BITS(LUM_FRAC_BITS)
  ) u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sq_valid[SQRT_STAGES]),
    .ready_o(sq_ready[SQRT_STAGES]),
    .data_i (sq_data[SQRT_STAGES]),
    .valid_o(out_if.valid),
    .ready_i(out_if.ready),
    .data_o (res)
  );

  assign out_if.data = res;

endmodule
